// ----- hdl/cpid_pkg.sv -----
// Shared widths, codes and the clamp function of the clamped PID controller.
package cpid_pkg;

    localparam int unsigned DATA_W = 16;   // error, feed-forward and drive width
    localparam int unsigned GAIN_W = 32;   // Q16.16 gain width
    localparam int unsigned FRAC_W = 16;   // fraction bits of a gain
    localparam int unsigned PROD_W = 49;   // gain times 17-bit error difference
    localparam int unsigned ADDR_W = 3;    // configuration register index

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [GAIN_W-1:0] gain_t;
    typedef logic signed [PROD_W-1:0] wide_t;

    // request codes
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_RESET  = 1'b1;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] CFG_KP_GAIN = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_KI_GAIN = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_KD_GAIN = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_OUT_MIN = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_OUT_MAX = 3'd4;

    // Lower limit is tested first, so inverted limits give lo for values below lo.
    function automatic data_t clamp(input wide_t x, input data_t lo, input data_t hi);
        data_t res;
        if (x < wide_t'(lo))
            res = lo;
        else if (x > wide_t'(hi))
            res = hi;
        else
            res = x[DATA_W-1:0];
        return res;
    endfunction

endpackage

// ----- hdl/cpid_req_if.sv -----
// Request channel of the clamped PID controller: request type, error and feed-forward.
interface cpid_req_if import cpid_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  req_type;
    data_t error_in;
    data_t feed_fwd;

    modport source (output valid, output req_type, output error_in, output feed_fwd,
                    input ready);
    modport sink   (input valid, input req_type, input error_in, input feed_fwd,
                    output ready);
endinterface

// ----- hdl/cpid_rsp_if.sv -----
// Response channel of the clamped PID controller: the clamped drive value.
interface cpid_rsp_if import cpid_pkg::*; ();
    logic  valid;
    logic  ready;
    data_t drive_out;

    modport source (output valid, output drive_out, input ready);
    modport sink   (input valid, input drive_out, output ready);
endinterface

// ----- hdl/clamped_pid_controller.sv -----
// Clamped discrete PID controller with anti-windup, one compute stage between two registers.
// Path: input register, then result register; a request waits while a response is untaken.
// Throughput: 1 transaction per cycle unless stalled; loop state updates as a result loads.
// Compute stage: three gain multipliers (32x16, 32x16, 32x17) and the clamp/sum tree.
// Reset (rst_n low, async): gains and limits 0, integral/last error/last output 0,
// first-frame flag set, both pipeline registers empty.
module clamped_pid_controller import cpid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0] cfg_data,
    cpid_req_if.sink          req,
    cpid_rsp_if.source        rsp
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    gain_t kp_gain_reg;
    gain_t ki_gain_reg;
    gain_t kd_gain_reg;
    data_t out_min_reg;
    data_t out_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_gain_reg <= '0;
            ki_gain_reg <= '0;
            kd_gain_reg <= '0;
            out_min_reg <= '0;
            out_max_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_KP_GAIN: kp_gain_reg <= cfg_data;
                CFG_KI_GAIN: ki_gain_reg <= cfg_data;
                CFG_KD_GAIN: kd_gain_reg <= cfg_data;
                CFG_OUT_MIN: out_min_reg <= cfg_data[DATA_W-1:0];
                CFG_OUT_MAX: out_max_reg <= cfg_data[DATA_W-1:0];
                default:     ;  // unused indexes are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register (stage 1)
    // ------------------------------------------------------------------
    logic  stg_valid_reg;
    logic  stg_type_reg;
    data_t stg_err_reg;
    data_t stg_ff_reg;
    logic  fire;       // stage 1 transaction moves into the result register
    logic  out_free;   // result register can take a new value this cycle

    assign out_free  = !rsp.valid || rsp.ready;
    assign fire      = stg_valid_reg && out_free;
    assign req.ready = !stg_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (req.ready)
            stg_valid_reg <= req.valid;
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            stg_type_reg <= req.req_type;
            stg_err_reg  <= req.error_in;
            stg_ff_reg   <= req.feed_fwd;
        end
    end

    // ------------------------------------------------------------------
    // Loop state
    // ------------------------------------------------------------------
    data_t integral_acc_reg;
    data_t last_error_reg;
    data_t last_output_reg;
    logic  first_frame_reg;

    // ------------------------------------------------------------------
    // Compute stage: products, floor shift, per-term clamps, sum clamp
    // ------------------------------------------------------------------
    logic signed [DATA_W:0] err_diff;
    wide_t prod_p;
    wide_t prod_i;
    wide_t prod_d;
    wide_t int_sum;
    wide_t drive_sum;
    data_t term_p;
    data_t term_d;
    data_t term_ff;
    data_t integral_next;
    data_t drive_next;
    logic  anti_windup_ok;

    assign err_diff = (DATA_W+1)'(stg_err_reg) - (DATA_W+1)'(last_error_reg);

    // >>> on a signed product is floor division by 2^16
    assign prod_p = (wide_t'(kp_gain_reg) * wide_t'(stg_err_reg)) >>> FRAC_W;
    assign prod_i = (wide_t'(ki_gain_reg) * wide_t'(stg_err_reg)) >>> FRAC_W;
    assign prod_d = (wide_t'(kd_gain_reg) * wide_t'(err_diff)) >>> FRAC_W;

    assign term_p  = clamp(prod_p, out_min_reg, out_max_reg);
    assign term_d  = first_frame_reg ? '0 : clamp(prod_d, out_min_reg, out_max_reg);
    assign term_ff = clamp(wide_t'(stg_ff_reg), out_min_reg, out_max_reg);

    // integrate only while the previous output sat strictly inside the limits
    assign anti_windup_ok = (out_min_reg < last_output_reg) && (last_output_reg < out_max_reg);
    assign int_sum        = prod_i + wide_t'(integral_acc_reg);
    assign integral_next  = anti_windup_ok ? clamp(int_sum, out_min_reg, out_max_reg)
                                           : integral_acc_reg;

    assign drive_sum  = wide_t'(term_p) + wide_t'(integral_next) + wide_t'(term_d)
                      + wide_t'(term_ff);
    assign drive_next = clamp(drive_sum, out_min_reg, out_max_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_acc_reg <= '0;
            last_error_reg   <= '0;
            last_output_reg  <= '0;
            first_frame_reg  <= 1'b1;
        end
        else if (fire)
        begin
            if (stg_type_reg == REQ_RESET)
            begin
                integral_acc_reg <= '0;
                last_error_reg   <= '0;
                last_output_reg  <= '0;
                first_frame_reg  <= 1'b1;
            end
            else
            begin
                integral_acc_reg <= integral_next;
                last_error_reg   <= stg_err_reg;
                last_output_reg  <= drive_next;
                first_frame_reg  <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register (stage 2)
    // ------------------------------------------------------------------
    logic  out_valid_reg;
    data_t drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= stg_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            drive_reg <= (stg_type_reg == REQ_RESET) ? '0 : drive_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.drive_out = drive_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an empty result register never stalls the request side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp.valid |-> req.ready)
        else $error("request stalled with empty result register");

    // a reset request answers 0
    a_reset_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && stg_type_reg == REQ_RESET) |=> (rsp.valid && rsp.drive_out == '0))
        else $error("reset request did not answer 0");

    // feedback copy of the output matches what was sent
    a_last_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (last_output_reg == rsp.drive_out))
        else $error("last output out of step with response");

    // an update clears the first-frame flag
    a_first_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && stg_type_reg == REQ_UPDATE) |=> !first_frame_reg)
        else $error("first-frame flag still set after update");

endmodule
